// ----- rtl/core/phong_fragment_shade_macros.svh -----
// Assertion helpers for the fragment shader core.
`ifndef PHONG_FRAGMENT_SHADE_MACROS_SVH
`define PHONG_FRAGMENT_SHADE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PHFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PHFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/phfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package phfs_pkg;

    localparam int VEC_W      = 33;   // exact difference / normal width
    localparam int UNIT_W     = 32;   // unit vector component, Q1.30
    localparam int NORM_LAT   = 34;   // normalizer pipeline depth
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SHADE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_POS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_POS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_POS_Z  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COLOR = 3'd7;

    localparam logic [15:0] WHITE_Q88 = 16'hFF00;
    localparam logic [15:0] SAT_Q88   = 16'hFFFF;
    localparam logic [47:0] LCOL_RST  = 48'h0100_0100_0100;
    localparam logic [26:0] AMB_Q30   = 27'd107374182;
    localparam logic [36:0] GLB_Q38   = 37'd109951162778;

    typedef logic signed [VEC_W-1:0]  t_diff;
    typedef logic signed [UNIT_W-1:0] t_unit;

    typedef struct packed {
        logic [15:0]        color_r;
        logic [15:0]        color_g;
        logic [15:0]        color_b;
        logic [7:0]         texel_r;
        logic [7:0]         texel_g;
        logic [7:0]         texel_b;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] frag_pos_x;
        logic signed [31:0] frag_pos_y;
        logic signed [31:0] frag_pos_z;
    } t_in;

    typedef struct packed {
        logic [15:0] shaded_r;
        logic [15:0] shaded_g;
        logic [15:0] shaded_b;
    } t_out;

endpackage

`default_nettype wire

// ----- rtl/core/phfs_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Vector normalizer: block-scale to 24 bits, sum of squares, digit-by-digit
// square root, then restoring divide per component. Fixed NORM_LAT depth.
module phfs_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  phfs_pkg::t_diff i_vec  [3],
    output phfs_pkg::t_unit o_unit [3]
);
    import phfs_pkg::*;

    localparam int MAG_W    = 24;
    localparam int SQ_STEPS = 25;
    localparam int SQ_STG   = (SQ_STEPS + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int Q_W      = 31;
    localparam int DIV_STG  = (Q_W + 1) / 2;
    localparam int DREM_W   = ROOT_W;
    localparam int SH_W     = 6;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << (Q_W - 1);

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } t_nside;

    // magnitude and max
    logic [VEC_W-1:0] r_n1_mag [3];
    logic [VEC_W-1:0] r_n1_max;
    logic [2:0]       r_n1_neg;
    logic [VEC_W-1:0] n_n1_mag [3];
    logic [VEC_W-1:0] n_n1_max;

    always_comb begin
        n_n1_max = '0;
        for (int i = 0; i < 3; i++) begin
            n_n1_mag[i] = i_vec[i][VEC_W-1] ? VEC_W'(-i_vec[i]) : VEC_W'(i_vec[i]);
            if (n_n1_mag[i] > n_n1_max) begin
                n_n1_max = n_n1_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_n1_mag[i] <= n_n1_mag[i];
                r_n1_neg[i] <= i_vec[i][VEC_W-1];
            end
            r_n1_max <= n_n1_max;
        end
    end

    // block scale so the largest magnitude lands in [2^23, 2^24)
    t_nside r_n2;
    t_nside n_n2;

    always_comb begin
        logic [SH_W-1:0] p;
        p = '0;
        for (int b = 0; b < VEC_W; b++) begin
            if (r_n1_max[b]) begin
                p = SH_W'(b);
            end
        end
        n_n2.zero = (r_n1_max == '0);
        n_n2.neg  = r_n1_neg;
        for (int i = 0; i < 3; i++) begin
            if (p > SH_W'(MAG_W - 1)) begin
                n_n2.mag[i] = MAG_W'(r_n1_mag[i] >> (p - SH_W'(MAG_W - 1)));
            end else begin
                n_n2.mag[i] = MAG_W'(r_n1_mag[i] << (SH_W'(MAG_W - 1) - p));
            end
        end
    end

    // squares
    logic [2*MAG_W-1:0] r_n3_sq [3];
    t_nside             r_n3_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n2      <= n_n2;
            r_n3_side <= r_n2;
            for (int i = 0; i < 3; i++) begin
                r_n3_sq[i] <= r_n2.mag[i] * r_n2.mag[i];
            end
        end
    end

    // square root, two digits a stage; index 0 holds the sum of squares
    logic [SREM_W-1:0] r_sq_rem  [SQ_STG+1];
    logic [ROOT_W-1:0] r_sq_root [SQ_STG+1];
    logic [RAD_W-1:0]  r_sq_rad  [SQ_STG+1];
    t_nside            r_sq_side [SQ_STG+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= RAD_W'(r_n3_sq[0]) + RAD_W'(r_n3_sq[1]) + RAD_W'(r_n3_sq[2]);
            r_sq_side[0] <= r_n3_side;
        end
    end

    for (genvar s = 0; s < SQ_STG; s++) begin : g_sqrt
        logic [SREM_W-1:0] n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [RAD_W-1:0]  n_rad;

        always_comb begin
            logic [SREM_W+1:0] rsh;
            logic [SREM_W+1:0] trial;
            rsh    = '0;
            trial  = '0;
            n_rem  = r_sq_rem[s];
            n_root = r_sq_root[s];
            n_rad  = r_sq_rad[s];
            for (int j = 0; j < 2; j++) begin
                if (2 * s + j < SQ_STEPS) begin
                    rsh   = {n_rem, n_rad[RAD_W-1 -: 2]};
                    trial = (SREM_W + 2)'({n_root, 2'b01});
                    if (rsh >= trial) begin
                        n_rem  = SREM_W'(rsh - trial);
                        n_root = {n_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = SREM_W'(rsh);
                        n_root = {n_root[ROOT_W-2:0], 1'b0};
                    end
                    n_rad = n_rad << 2;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[s+1]  <= n_rem;
                r_sq_root[s+1] <= n_root;
                r_sq_rad[s+1]  <= n_rad;
                r_sq_side[s+1] <= r_sq_side[s];
            end
        end
    end

    // restoring divide: (mag << 30) / len, first stage settles the integer bit
    logic [ROOT_W-1:0] r_dv_len  [DIV_STG];
    logic [DREM_W-1:0] r_dv_rem  [DIV_STG][3];
    logic [Q_W-1:0]    r_dv_q    [DIV_STG][3];
    t_nside            r_dv_side [DIV_STG];

    for (genvar d = 0; d < DIV_STG; d++) begin : g_div
        logic [ROOT_W-1:0] w_len;
        t_nside            w_side;
        logic [DREM_W-1:0] n_rem [3];
        logic [Q_W-1:0]    n_q   [3];

        if (d == 0) begin : g_first
            assign w_len  = r_sq_root[SQ_STG];
            assign w_side = r_sq_side[SQ_STG];
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    if (DREM_W'(w_side.mag[i]) >= w_len) begin
                        n_rem[i] = DREM_W'(w_side.mag[i]) - w_len;
                        n_q[i]   = Q_W'(1);
                    end else begin
                        n_rem[i] = DREM_W'(w_side.mag[i]);
                        n_q[i]   = '0;
                    end
                end
            end
        end else begin : g_next
            assign w_len  = r_dv_len[d-1];
            assign w_side = r_dv_side[d-1];
            always_comb begin
                logic [DREM_W:0] r2;
                r2 = '0;
                for (int i = 0; i < 3; i++) begin
                    n_rem[i] = r_dv_rem[d-1][i];
                    n_q[i]   = r_dv_q[d-1][i];
                    for (int j = 0; j < 2; j++) begin
                        r2 = {n_rem[i], 1'b0};
                        if (r2 >= {1'b0, w_len}) begin
                            n_rem[i] = DREM_W'(r2 - {1'b0, w_len});
                            n_q[i]   = {n_q[i][Q_W-2:0], 1'b1};
                        end else begin
                            n_rem[i] = DREM_W'(r2);
                            n_q[i]   = {n_q[i][Q_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_len[d]  <= w_len;
                r_dv_side[d] <= w_side;
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[d][i] <= n_rem[i];
                    r_dv_q[d][i]   <= n_q[i];
                end
            end
        end
    end

    // clamp, sign, zero-vector override
    t_unit r_unit [3];
    t_unit n_unit [3];

    always_comb begin
        logic [Q_W-1:0] qc;
        qc = '0;
        for (int i = 0; i < 3; i++) begin
            qc = (r_dv_q[DIV_STG-1][i] > Q_ONE) ? Q_ONE : r_dv_q[DIV_STG-1][i];
            if (r_dv_side[DIV_STG-1].zero) begin
                n_unit[i] = '0;
            end else if (r_dv_side[DIV_STG-1].neg[i]) begin
                n_unit[i] = -UNIT_W'(qc);
            end else begin
                n_unit[i] = UNIT_W'(qc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;

endmodule

`default_nettype wire

// ----- rtl/core/phong_fragment_shade.sv -----
// Throughput: one fragment per cycle while the output is not stalled; every stage does a fixed slice of work.
// Flow control: one global advance; the pipe freezes while the output beat waits.
// Reset: synchronous, active low; clears valid bits and positions, sets mode to 1 and light colour to LCOL_RST.
// Light registers are read at entry, light colour later: write them only while idle.
`timescale 1ns / 1ps
`default_nettype none

`include "phong_fragment_shade_macros.svh"

module phong_fragment_shade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  phfs_pkg::t_in                   i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output phfs_pkg::t_out                  o_data,
    input  logic                            i_cfg_we,
    input  logic [phfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [phfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import phfs_pkg::*;

    // stage map: 0 entry, NORM_LAT unit vectors, then lighting, squarings, colour
    localparam int ST_NORM  = NORM_LAT;
    localparam int ST_L3    = ST_NORM + 3;
    localparam int ST_F     = ST_NORM + 15;
    localparam int ST_G     = ST_F + 1;
    localparam int ST_H     = ST_G + 1;
    localparam int ST_K     = ST_H + 3;
    localparam int PIPE_LAT = ST_K + 1;
    localparam int DIFF_DLY = ST_F - ST_L3;
    localparam int SPOW     = 7;          // seven squarings give power 128
    localparam int SQP_W    = 62;

    localparam logic signed [63:0] ONE_Q30  = 64'sh4000_0000;
    localparam logic signed [63:0] ONE_Q60  = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q58  = 64'sh0400_0000_0000_0000;
    localparam logic signed [63:0] RND_Q30  = 64'sh3FFF_FFFF;
    localparam logic signed [63:0] RND_Q32  = 64'sh0_FFFF_FFFF;
    localparam logic [42:0]        SAT_LIM  = 43'd16711680;   // 255 << 16
    localparam logic [15:0]        RCP_255  = 16'd32897;      // ceil(2^23 / 255)

    typedef struct packed {
        logic [2:0][15:0] col;
        logic [2:0][7:0]  tex;
        logic             mode;
    } t_side;

    //--------------------------------------------------------------------
    // configuration registers
    //--------------------------------------------------------------------
    logic               r_mode;
    logic signed [31:0] r_light [3];
    logic signed [31:0] r_view  [3];
    logic [47:0]        r_lcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            for (int i = 0; i < 3; i++) begin
                r_light[i] <= '0;
                r_view[i]  <= '0;
            end
            r_lcol <= LCOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHADE_MODE:  r_mode     <= i_cfg_wdata[0];
                CFG_LIGHT_POS_X: r_light[0] <= i_cfg_wdata[31:0];
                CFG_LIGHT_POS_Y: r_light[1] <= i_cfg_wdata[31:0];
                CFG_LIGHT_POS_Z: r_light[2] <= i_cfg_wdata[31:0];
                CFG_VIEW_POS_X:  r_view[0]  <= i_cfg_wdata[31:0];
                CFG_VIEW_POS_Y:  r_view[1]  <= i_cfg_wdata[31:0];
                CFG_VIEW_POS_Z:  r_view[2]  <= i_cfg_wdata[31:0];
                CFG_LIGHT_COLOR: r_lcol     <= i_cfg_wdata;
                default:         r_lcol     <= r_lcol;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // flow control: valid bits ride along, whole pipe moves together
    //--------------------------------------------------------------------
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_adv;

    assign w_adv   = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // colour, texel and mode travel beside the math
    t_side r_side [PIPE_LAT];
    t_side n_side;

    always_comb begin
        n_side.col  = {i_data.color_b, i_data.color_g, i_data.color_r};
        n_side.tex  = {i_data.texel_b, i_data.texel_g, i_data.texel_r};
        n_side.mode = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k < PIPE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    //--------------------------------------------------------------------
    // stage 0: exact 33-bit normal and light / view directions
    //--------------------------------------------------------------------
    logic signed [31:0] w_nm [3];
    logic signed [31:0] w_fp [3];
    t_diff              r_s0_n [3];
    t_diff              r_s0_l [3];
    t_diff              r_s0_v [3];

    assign w_nm[0] = i_data.normal_x;
    assign w_nm[1] = i_data.normal_y;
    assign w_nm[2] = i_data.normal_z;
    assign w_fp[0] = i_data.frag_pos_x;
    assign w_fp[1] = i_data.frag_pos_y;
    assign w_fp[2] = i_data.frag_pos_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s0_n[i] <= VEC_W'(w_nm[i]);
                r_s0_l[i] <= VEC_W'(r_light[i]) - VEC_W'(w_fp[i]);
                r_s0_v[i] <= VEC_W'(r_view[i]) - VEC_W'(w_fp[i]);
            end
        end
    end

    //--------------------------------------------------------------------
    // three normalizers in lockstep
    //--------------------------------------------------------------------
    t_unit w_un [3];
    t_unit w_ul [3];
    t_unit w_uv [3];

    phfs_norm u_norm_n (.i_clk(i_clk), .i_en(w_adv), .i_vec(r_s0_n), .o_unit(w_un));
    phfs_norm u_norm_l (.i_clk(i_clk), .i_en(w_adv), .i_vec(r_s0_l), .o_unit(w_ul));
    phfs_norm u_norm_v (.i_clk(i_clk), .i_en(w_adv), .i_vec(r_s0_v), .o_unit(w_uv));

    //--------------------------------------------------------------------
    // N.L, diffuse term, reflect vector, V.R
    //--------------------------------------------------------------------
    logic signed [63:0] r_l1_p [3];
    t_unit              r_l1_n [3];
    t_unit              r_l1_l [3];
    t_unit              r_l1_v [3];
    logic signed [63:0] r_l2_s;
    t_unit              r_l2_n [3];
    t_unit              r_l2_l [3];
    t_unit              r_l2_v [3];
    logic signed [31:0] r_l3_d;
    t_unit              r_l3_n [3];
    t_unit              r_l3_l [3];
    t_unit              r_l3_v [3];
    logic signed [63:0] r_l4_pd [3];
    t_unit              r_l4_l [3];
    t_unit              r_l4_v [3];
    logic signed [31:0] r_l5_rf [3];
    t_unit              r_l5_v [3];
    logic signed [63:0] r_l6_p [3];
    logic [30:0]        r_l7_spec;
    logic [30:0]        r_diff_dly [DIFF_DLY];

    logic signed [31:0] n_l3_d;
    logic [30:0]        n_l3_diff;
    logic signed [31:0] n_l5_rf [3];
    logic [30:0]        n_l7_spec;

    // d = trunc(N.I / 2^30) clamped, I = -L; diffuse from N.L = -(N.I)
    always_comb begin
        logic signed [63:0] ns;
        logic signed [63:0] tq;
        ns = -r_l2_s;
        tq = (ns + ((ns < 0) ? RND_Q30 : 64'sd0)) >>> 30;
        if (tq > ONE_Q30) begin
            n_l3_d = ONE_Q30[31:0];
        end else if (tq < -ONE_Q30) begin
            n_l3_d = -ONE_Q30[31:0];
        end else begin
            n_l3_d = tq[31:0];
        end
        if (r_l2_s < 0) begin
            n_l3_diff = '0;
        end else if (r_l2_s > ONE_Q60) begin
            n_l3_diff = ONE_Q60[60:30];
        end else begin
            n_l3_diff = r_l2_s[60:30];
        end
    end

    // R = (I * 2^30 - 2 d N) / 2^32, truncated toward zero
    always_comb begin
        logic signed [63:0] inc;
        logic signed [63:0] val;
        logic signed [63:0] tq;
        inc = '0;
        val = '0;
        tq  = '0;
        for (int i = 0; i < 3; i++) begin
            inc = -64'(r_l4_l[i]);
            val = (inc <<< 30) - (r_l4_pd[i] <<< 1);
            tq  = (val + ((val < 0) ? RND_Q32 : 64'sd0)) >>> 32;
            n_l5_rf[i] = tq[31:0];
        end
    end

    // spec base = clamp(V.R, 0, 2^58) >> 28
    always_comb begin
        logic signed [63:0] s;
        s = r_l6_p[0] + r_l6_p[1] + r_l6_p[2];
        if (s < 0) begin
            n_l7_spec = '0;
        end else if (s > ONE_Q58) begin
            n_l7_spec = ONE_Q58[58:28];
        end else begin
            n_l7_spec = s[58:28];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_l1_p[i]  <= 64'(w_un[i]) * 64'(w_ul[i]);
                r_l4_pd[i] <= 64'(r_l3_d) * 64'(r_l3_n[i]);
                r_l5_rf[i] <= n_l5_rf[i];
                r_l6_p[i]  <= 64'(r_l5_v[i]) * 64'(r_l5_rf[i]);
            end
            r_l1_n <= w_un;
            r_l1_l <= w_ul;
            r_l1_v <= w_uv;
            r_l2_s <= r_l1_p[0] + r_l1_p[1] + r_l1_p[2];
            r_l2_n <= r_l1_n;
            r_l2_l <= r_l1_l;
            r_l2_v <= r_l1_v;
            r_l3_d <= n_l3_d;
            r_l3_n <= r_l2_n;
            r_l3_l <= r_l2_l;
            r_l3_v <= r_l2_v;
            r_l4_l <= r_l3_l;
            r_l4_v <= r_l3_v;
            r_l5_v <= r_l4_v;
            r_l7_spec <= n_l7_spec;
            r_diff_dly[0] <= n_l3_diff;
            for (int k = 1; k < DIFF_DLY; k++) begin
                r_diff_dly[k] <= r_diff_dly[k-1];
            end
        end
    end

    //--------------------------------------------------------------------
    // spec^128: one squaring per stage, rescale folded into the next
    //--------------------------------------------------------------------
    logic [SQP_W-1:0] r_sqp [SPOW];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqp[0] <= SQP_W'(r_l7_spec) * SQP_W'(r_l7_spec);
            for (int k = 1; k < SPOW; k++) begin
                r_sqp[k] <= SQP_W'(r_sqp[k-1][60:30]) * SQP_W'(r_sqp[k-1][60:30]);
            end
        end
    end

    //--------------------------------------------------------------------
    // factor, light colour, texel weighting, divide by 255 * 2^16
    //--------------------------------------------------------------------
    logic [31:0] r_f;
    logic [47:0] r_g_m  [3];
    logic [23:0] r_g_ct [3];
    logic [26:0] r_h_t  [3];
    logic [31:0] r_h_a  [3];
    logic [58:0] r_i_p  [3];
    logic [16:0] r_j_qe [3];
    logic [23:0] r_j_x  [3];
    logic        r_j_sat [3];
    t_out        r_out;

    logic [48:0] w_h_sum [3];
    logic [42:0] w_j_x   [3];
    logic [39:0] w_j_prd [3];
    logic [24:0] w_k_chk [3];
    logic [16:0] w_k_q   [3];
    logic [15:0] w_k_ch  [3];
    logic [30:0] w_f_spec;

    assign w_f_spec = r_sqp[SPOW-1][60:30];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_h_sum[i] = 49'(r_g_m[i]) + 49'(GLB_Q38);
            w_j_x[i]   = r_i_p[i][58:16];
            w_j_prd[i] = 40'(w_j_x[i][23:0]) * 40'(RCP_255);
            w_k_chk[i] = {r_j_qe[i], 8'b0} - 25'(r_j_qe[i]);
            w_k_q[i]   = (w_k_chk[i] > 25'(r_j_x[i])) ? (r_j_qe[i] - 17'd1) : r_j_qe[i];
            if (!r_side[ST_K-1].mode) begin
                w_k_ch[i] = WHITE_Q88;
            end else if (r_j_sat[i]) begin
                w_k_ch[i] = SAT_Q88;
            end else begin
                w_k_ch[i] = w_k_q[i][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f <= 32'(AMB_Q30) + 32'(r_diff_dly[DIFF_DLY-1]) + 32'(w_f_spec[30:1]);
            for (int i = 0; i < 3; i++) begin
                r_g_m[i]   <= 48'(r_f) * 48'(r_lcol[16*i +: 16]);
                r_g_ct[i]  <= 24'(r_side[ST_G-1].col[i]) * 24'(r_side[ST_G-1].tex[i]);
                r_h_t[i]   <= w_h_sum[i][48:22];
                r_h_a[i]   <= 32'(r_g_ct[i]) * 32'(r_side[ST_H-1].tex[i]);
                r_i_p[i]   <= 59'(r_h_t[i]) * 59'(r_h_a[i]);
                r_j_sat[i] <= (w_j_x[i] >= SAT_LIM);
                r_j_x[i]   <= w_j_x[i][23:0];
                r_j_qe[i]  <= w_j_prd[i][39:23];
            end
            r_out.shaded_r <= w_k_ch[0];
            r_out.shaded_g <= w_k_ch[1];
            r_out.shaded_b <= w_k_ch[2];
        end
    end

    assign o_data = r_out;

    //--------------------------------------------------------------------
    // checks
    //--------------------------------------------------------------------
    `PHFS_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0], "accepted beat missing from entry stage")
    `PHFS_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_adv, r_vld == $past(r_vld), "valid bits moved during stall")
    `PHFS_ASSERT_NOW(a_white_out, i_clk, i_rst_n, o_valid && !r_side[PIPE_LAT-1].mode, o_data.shaded_r == WHITE_Q88 && o_data.shaded_g == WHITE_Q88 && o_data.shaded_b == WHITE_Q88, "light-source beat not white")

endmodule

`default_nettype wire

// ----- tb/tb_phong_fragment_shade.sv -----
`timescale 1ns / 1ps

module tb_phong_fragment_shade;
    import phfs_pkg::*;

    localparam int  SETTLE_CYCLES = 80;     // pipe is 55 deep, plus margin
    localparam int  STALL_LIMIT   = 5000;   // cycles with no beat on either side
    localparam longint ONE_Q30    = 64'sd1073741824;

    // Shading predictor and store of expected shaded colors.
    class shade_scoreboard;
        bit           mode;
        longint       light[3];
        longint       view[3];
        logic [47:0]  lcol;
        t_out         pending[$];
        int           errors;

        function new();
            mode  = 1'b1;
            lcol  = LCOL_RST;
            for (int i = 0; i < 3; i++) begin
                light[i] = 0;
                view[i]  = 0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            longint s;
            s = longint'($signed(v[31:0]));
            case (idx)
                CFG_SHADE_MODE:  mode = v[0];
                CFG_LIGHT_POS_X: light[0] = s;
                CFG_LIGHT_POS_Y: light[1] = s;
                CFG_LIGHT_POS_Z: light[2] = s;
                CFG_VIEW_POS_X:  view[0] = s;
                CFG_VIEW_POS_Y:  view[1] = s;
                CFG_VIEW_POS_Z:  view[2] = s;
                CFG_LIGHT_COLOR: lcol = v[47:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bit_w;
            res   = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        // Direction to Q1.30 unit vector; magnitudes are first scaled so the
        // largest lands in [2^23, 2^24).
        function void to_unit(input longint v[3], output longint u[3]);
            longint unsigned mag[3], m, sum, len, q;
            m = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                for (int i = 0; i < 3; i++) u[i] = 0;
                return;
            end
            while (m >= (64'd1 << 24)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (m < (64'd1 << 23)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] << 30) / len;
                if (q > ONE_Q30) q = ONE_Q30;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function longint dot3(longint a[3], longint b[3]);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        function t_out shade(t_in d);
            t_out   r;
            longint nv[3], lv[3], vv[3], nu[3], lu[3], vu[3], inc[3], rf[3], fp[3];
            longint dd;
            longint unsigned spec, diff, f, lc, col, tx, t, prod;
            logic [15:0] chan[3];
            longint unsigned colv[3], texv[3];
            if (!mode) begin
                r.shaded_r = WHITE_Q88;
                r.shaded_g = WHITE_Q88;
                r.shaded_b = WHITE_Q88;
                return r;
            end
            fp[0] = d.frag_pos_x;  fp[1] = d.frag_pos_y;  fp[2] = d.frag_pos_z;
            nv[0] = d.normal_x;    nv[1] = d.normal_y;    nv[2] = d.normal_z;
            for (int i = 0; i < 3; i++) begin
                lv[i] = light[i] - fp[i];
                vv[i] = view[i] - fp[i];
            end
            to_unit(nv, nu);
            to_unit(lv, lu);
            to_unit(vv, vu);

            // reflect the incident direction about the normal, Q.28
            for (int i = 0; i < 3; i++) inc[i] = -lu[i];
            dd = dot3(nu, inc) / ONE_Q30;
            if (dd > ONE_Q30)  dd = ONE_Q30;
            if (dd < -ONE_Q30) dd = -ONE_Q30;
            for (int i = 0; i < 3; i++)
                rf[i] = (inc[i] * ONE_Q30 - 2 * dd * nu[i]) / 64'sd4294967296;

            dd = dot3(vu, rf);
            if (dd < 0) dd = 0;
            if (dd > (64'sd1 <<< 58)) dd = 64'sd1 <<< 58;
            spec = longint'(dd) >> 28;
            for (int i = 0; i < 7; i++) spec = (spec * spec) >> 30;

            dd = dot3(nu, lu);
            if (dd < 0) dd = 0;
            if (dd > (64'sd1 <<< 60)) dd = 64'sd1 <<< 60;
            diff = longint'(dd) >> 30;

            f = AMB_Q30 + diff + (spec >> 1);
            colv[0] = d.color_r;  colv[1] = d.color_g;  colv[2] = d.color_b;
            texv[0] = d.texel_r;  texv[1] = d.texel_g;  texv[2] = d.texel_b;
            for (int i = 0; i < 3; i++) begin
                lc   = lcol[16*i +: 16];
                col  = colv[i];
                tx   = texv[i];
                t    = (f * lc + GLB_Q38) >> 22;
                prod = (t * (col * tx) * tx) / (64'd255 << 16);
                chan[i] = (prod > 64'hFFFF) ? SAT_Q88 : prod[15:0];
            end
            r.shaded_r = chan[0];
            r.shaded_g = chan[1];
            r.shaded_b = chan[2];
            return r;
        endfunction

        function void note_fragment(t_in d);
            pending.push_back(shade(d));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.shaded_r !== want.shaded_r || got.shaded_g !== want.shaded_g ||
                    got.shaded_b !== want.shaded_b) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch r/g/b: expected %h %h %h, got %h %h %h",
                             want.shaded_r, want.shaded_g, want.shaded_b,
                             got.shaded_r, got.shaded_g, got.shaded_b);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in                   i_data;
    logic                  o_valid;
    logic                  i_ready;
    t_out                  o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    shade_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;
    int quiet_cycles;

    phong_fragment_shade DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Output side: check beats, toggle ready, and watch for a hung pipe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_data);
            if ((o_valid && i_ready) || (i_valid && o_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Idle mix moves with progress: sparse receiver first, then sparse sender,
    // then full rate both ways.
    function void pick_idle_mix();
        if (beats_sent < 200) begin
            send_idle_pct = 9;
            recv_idle_pct = 87;
        end else if (beats_sent < 400) begin
            send_idle_pct = 87;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // One input beat; valid stays up across back-to-back beats.
    task automatic send_fragment(t_in d);
        pick_idle_mix();
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (!o_ready);
        sb.note_fragment(d);
        beats_sent++;
    endtask

    // Hold off until the pipe has drained; registers may change only then.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_positions(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                 logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        cfg_write(CFG_LIGHT_POS_X, {16'h0, lx});
        cfg_write(CFG_LIGHT_POS_Y, {16'h0, ly});
        cfg_write(CFG_LIGHT_POS_Z, {16'h0, lz});
        cfg_write(CFG_VIEW_POS_X,  {16'h0, vx});
        cfg_write(CFG_VIEW_POS_Y,  {16'h0, vy});
        cfg_write(CFG_VIEW_POS_Z,  {16'h0, vz});
    endtask

    function t_in make_frag(logic [15:0] c, logic [7:0] tx,
                            logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        t_in d;
        d.color_r = c;   d.color_g = c;   d.color_b = c;
        d.texel_r = tx;  d.texel_g = tx;  d.texel_b = tx;
        d.normal_x = nx;    d.normal_y = ny;    d.normal_z = nz;
        d.frag_pos_x = px;  d.frag_pos_y = py;  d.frag_pos_z = pz;
        return d;
    endfunction

    function logic [15:0] rand_color();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0100;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function logic [7:0] rand_texel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly scene-like coordinates (a few units around the origin),
    // with some full-range values.
    function logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: v = $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
        endcase
        return v;
    endfunction

    function t_in rand_frag();
        t_in d;
        d.color_r = rand_color();  d.color_g = rand_color();  d.color_b = rand_color();
        d.texel_r = rand_texel();  d.texel_g = rand_texel();  d.texel_b = rand_texel();
        d.normal_x = rand_coord();
        d.normal_y = rand_coord();
        d.normal_z = rand_coord();
        d.frag_pos_x = rand_coord();
        d.frag_pos_y = rand_coord();
        d.frag_pos_z = rand_coord();
        case ($urandom_range(0, 19))
            0: begin                        // degenerate normal
                d.normal_x = '0;  d.normal_y = '0;  d.normal_z = '0;
            end
            1: begin                        // fragment sits on the light
                d.frag_pos_x = sb.light[0][31:0];
                d.frag_pos_y = sb.light[1][31:0];
                d.frag_pos_z = sb.light[2][31:0];
            end
            2: begin                        // fragment sits on the viewer
                d.frag_pos_x = sb.view[0][31:0];
                d.frag_pos_y = sb.view[1][31:0];
                d.frag_pos_z = sb.view[2][31:0];
            end
            3, 4: begin                     // normal facing the light: strong diffuse
                d.normal_x = sb.light[0][31:0] - d.frag_pos_x;
                d.normal_y = sb.light[1][31:0] - d.frag_pos_y;
                d.normal_z = sb.light[2][31:0] - d.frag_pos_z;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_fragment(rand_frag());
    endtask

    initial begin
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_data        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SHADE_MODE;
        i_cfg_wdata   = '0;
        beats_sent    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 9;
        recv_idle_pct = 87;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: light and viewer at the origin, unit light color.
        send_fragment(make_frag(16'h0000, 8'h00, '0, '0, '0, '0, '0, '0));
        send_fragment(make_frag(16'hFFFF, 8'hFF, 32'h0001_0000, '0, '0,
                                32'hFFFF_0000, '0, '0));
        send_fragment(make_frag(16'hFFFF, 8'hFF, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000));
        send_fragment(make_frag(16'h0100, 8'h80, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF));
        send_fragment(make_frag(16'h8000, 8'h01, '0, '0, '0, 32'h0002_0000, '0, '0));
        send_fragment(make_frag(16'h0001, 8'hFF, 32'h0000_0001, '0, '0, '0, '0, '0));
        drain_pipe();

        // Light and viewer on the +z axis: mirror reflection, full highlight.
        set_positions('0, '0, 32'h0004_0000, '0, '0, 32'h0004_0000);
        cfg_done();
        send_fragment(make_frag(16'h0100, 8'hFF, '0, '0, 32'h0001_0000, '0, '0, '0));
        send_fragment(make_frag(16'h4000, 8'hC0, '0, '0, 32'h0001_0000, '0, '0, '0));
        send_fragment(make_frag(16'h0100, 8'hFF, '0, '0, 32'hFFFF_0000, '0, '0, '0));
        send_fragment(make_frag(16'h0100, 8'hFF, 32'h0000_8000, '0, 32'h0001_0000,
                                '0, '0, '0));
        send_fragment(make_frag(16'hFFFF, 8'hFF, '0, '0, 32'h0001_0000, '0, '0, '0));
        send_fragment(make_frag(16'h0100, 8'h7F, '0, '0, 32'h0001_0000,
                                '0, '0, 32'h0004_0000));
        drain_pipe();

        // Light-source mode: white regardless of inputs.
        cfg_write(CFG_SHADE_MODE, 48'd0);
        cfg_done();
        send_fragment(make_frag(16'h0000, 8'h00, '0, '0, '0, '0, '0, '0));
        send_fragment(make_frag(16'hFFFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, '0,
                                32'h1234_5678, '0, '0));
        drain_pipe();

        // Random phases over a spread of register settings.
        cfg_write(CFG_SHADE_MODE, 48'd1);
        set_positions(32'h0003_0000, 32'h0005_0000, 32'h0002_0000,
                      32'hFFFE_0000, 32'h0004_0000, 32'h0006_0000);
        cfg_done();
        send_random(110);
        drain_pipe();

        cfg_write(CFG_LIGHT_COLOR, 48'hFFFF_FFFF_FFFF);
        set_positions(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        cfg_done();
        send_random(100);
        drain_pipe();

        cfg_write(CFG_LIGHT_COLOR, 48'h0);
        set_positions(32'h8000_0000, '0, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, '0);
        cfg_done();
        send_random(60);
        drain_pipe();

        cfg_write(CFG_SHADE_MODE, 48'd0);
        cfg_done();
        send_random(40);
        drain_pipe();

        cfg_write(CFG_SHADE_MODE, 48'd1);
        cfg_write(CFG_LIGHT_COLOR, {16'($urandom_range(0, 16'hFFFF)), 16'h0180, 16'h00C0});
        set_positions($urandom_range(0, 32'h000C_0000) - 32'h0006_0000, 32'h0008_0000,
                      $urandom_range(0, 32'h000C_0000) - 32'h0006_0000,
                      '0, 32'h0003_0000, 32'h0008_0000);
        cfg_done();
        send_random(150);
        drain_pipe();

        cfg_write(CFG_LIGHT_COLOR, 48'({$urandom, $urandom}));
        set_positions($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        cfg_done();
        send_random(140);

        drain_pipe();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- phong_fragment_shade.f -----
+incdir+rtl/core
rtl/core/phfs_pkg.sv
rtl/core/phfs_norm.sv
rtl/core/phong_fragment_shade.sv
tb/tb_phong_fragment_shade.sv
